### rtl/dtt_pkg.sv
// Shared constants, command and status types of the distribution tail tracker.
package dtt_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SIZE_W      = $clog2(STORE_DEPTH + 1);
  localparam int ACC_W       = 32 + ADDR_W;
  localparam int TFP_W       = 63 + 16;
  localparam int PADDR_W     = 5;

  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_STORE_COUNT = 3'd1;
  localparam logic [2:0] REG_LOW_INDEX   = 3'd2;
  localparam logic [2:0] REG_HIGH_INDEX  = 3'd3;
  localparam logic [2:0] REG_TAIL_FRAC   = 3'd4;

  localparam logic [1:0]  MODE_RST        = 2'd0;
  localparam logic [10:0] STORE_COUNT_RST = 11'd1024;
  localparam logic [9:0]  LOW_INDEX_RST   = 10'd0;
  localparam logic [9:0]  HIGH_INDEX_RST  = 10'd1023;
  localparam logic [15:0] TAIL_FRAC_RST   = 16'd1638;

  localparam logic [1:0] MODE_TAIL = 2'd0;

  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_SW   = 3'd1;
  localparam logic [2:0] MUL_SQ   = 3'd2;
  localparam logic [2:0] MUL_HI   = 3'd3;
  localparam logic [2:0] MUL_LO   = 3'd4;
  localparam logic [2:0] MUL_TL   = 3'd5;
  localparam logic [2:0] MUL_TH   = 3'd6;

  localparam logic [2:0] PTR_HOLD   = 3'd0;
  localparam logic [2:0] PTR_COUNT  = 3'd1;
  localparam logic [2:0] PTR_HALF   = 3'd2;
  localparam logic [2:0] PTR_HALFM1 = 3'd3;
  localparam logic [2:0] PTR_INC    = 3'd4;
  localparam logic [2:0] PTR_DEC    = 3'd5;
  localparam logic [2:0] PTR_ZERO   = 3'd6;
  localparam logic [2:0] PTR_LAST   = 3'd7;

  localparam logic [3:0] RD_PTR    = 4'd0;
  localparam logic [3:0] RD_PM1    = 4'd1;
  localparam logic [3:0] RD_PM2    = 4'd2;
  localparam logic [3:0] RD_PP1    = 4'd3;
  localparam logic [3:0] RD_PP2    = 4'd4;
  localparam logic [3:0] RD_HALF   = 4'd5;
  localparam logic [3:0] RD_HALFM1 = 4'd6;
  localparam logic [3:0] RD_ZERO   = 4'd7;
  localparam logic [3:0] RD_ONE    = 4'd8;
  localparam logic [3:0] RD_LAST   = 4'd9;
  localparam logic [3:0] RD_LASTM1 = 4'd10;
  localparam logic [3:0] RD_LI     = 4'd11;
  localparam logic [3:0] RD_HIX    = 4'd12;

  typedef struct packed {
    logic       load;
    logic       clear;
    logic [2:0] mul_op;
    logic       acc_sum;
    logic       acc_sq;
    logic       save_mlo;
    logic       save_sqp;
    logic       tfp_load;
    logic       tfp_add;
    logic [3:0] rd_sel;
    logic [2:0] ptr_op;
    logic       count_inc;
    logic       reject;
    logic       wr_shift;
    logic       wr_place;
    logic       wacc_load;
    logic       wacc_add;
    logic       set_li;
    logic       set_hix;
    logic       set_fixed;
    logic       bnd_start;
    logic       lo_load;
    logic       hi_load;
  } dtt_cmd_t;

  typedef struct packed {
    logic func_clear;
    logic mode_full;
    logic mode_walk;
    logic count_lt_n;
    logic ptr_zero;
    logic ptr_one;
    logic ptr_last;
    logic ptr_penult;
    logic gt_x;
    logic lt_x;
    logic below;
  } dtt_status_t;

endpackage

### rtl/dtt_ctrl.sv
// Sequencer of the tracker: steps the datapath through one word's work.
module dtt_ctrl import dtt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  dtt_status_t st,
  output dtt_cmd_t    cmd,
  output logic        busy,
  output logic        done
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CLR     = 5'd1;
  localparam logic [4:0] S_M1      = 5'd2;
  localparam logic [4:0] S_M2      = 5'd3;
  localparam logic [4:0] S_M3      = 5'd4;
  localparam logic [4:0] S_M4      = 5'd5;
  localparam logic [4:0] S_M5      = 5'd6;
  localparam logic [4:0] S_DEC     = 5'd7;
  localparam logic [4:0] S_THI_CMP = 5'd8;
  localparam logic [4:0] S_TLO_CMP = 5'd9;
  localparam logic [4:0] S_DN_ISS  = 5'd10;
  localparam logic [4:0] S_DN_CMP  = 5'd11;
  localparam logic [4:0] S_UP_ISS  = 5'd12;
  localparam logic [4:0] S_UP_CMP  = 5'd13;
  localparam logic [4:0] S_PLACE   = 5'd14;
  localparam logic [4:0] S_BND     = 5'd15;
  localparam logic [4:0] S_WP1     = 5'd16;
  localparam logic [4:0] S_WP2     = 5'd17;
  localparam logic [4:0] S_WP3     = 5'd18;
  localparam logic [4:0] S_WL1     = 5'd19;
  localparam logic [4:0] S_WLS     = 5'd20;
  localparam logic [4:0] S_WH0     = 5'd21;
  localparam logic [4:0] S_WH1     = 5'd22;
  localparam logic [4:0] S_WHS     = 5'd23;
  localparam logic [4:0] S_RLO     = 5'd24;
  localparam logic [4:0] S_RHI     = 5'd25;
  localparam logic [4:0] S_RDN     = 5'd26;
  localparam logic [4:0] S_OUT     = 5'd27;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = st.func_clear ? S_CLR : S_M1;
        end
      end
      S_CLR: begin
        cmd.clear  = 1'b1;
        state_next = S_BND;
      end
      S_M1: begin
        cmd.mul_op = MUL_SW;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.acc_sum = 1'b1;
        cmd.mul_op  = MUL_SQ;
        state_next  = S_M3;
      end
      S_M3: begin
        cmd.save_mlo = 1'b1;
        cmd.mul_op   = MUL_HI;
        state_next   = S_M4;
      end
      S_M4: begin
        cmd.save_sqp = 1'b1;
        cmd.mul_op   = MUL_LO;
        state_next   = S_M5;
      end
      S_M5: begin
        cmd.acc_sq = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        if (st.mode_full && !st.count_lt_n) begin
          cmd.reject = 1'b1;
          state_next = S_BND;
        end else if (st.count_lt_n) begin
          cmd.ptr_op    = PTR_COUNT;
          cmd.count_inc = 1'b1;
          state_next    = S_DN_ISS;
        end else begin
          cmd.count_inc = 1'b1;
          cmd.rd_sel    = RD_HALF;
          state_next    = S_THI_CMP;
        end
      end
      S_THI_CMP: begin
        if (st.lt_x) begin
          cmd.ptr_op = PTR_HALF;
          state_next = S_UP_ISS;
        end else begin
          cmd.rd_sel = RD_HALFM1;
          state_next = S_TLO_CMP;
        end
      end
      S_TLO_CMP: begin
        if (st.gt_x) begin
          cmd.ptr_op = PTR_HALFM1;
          state_next = S_DN_ISS;
        end else begin
          state_next = S_BND;
        end
      end
      S_DN_ISS: begin
        if (st.ptr_zero) begin
          state_next = S_PLACE;
        end else begin
          cmd.rd_sel = RD_PM1;
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        // shift the larger entry up one place and move the hole down
        if (st.gt_x) begin
          cmd.wr_shift = 1'b1;
          cmd.ptr_op   = PTR_DEC;
          cmd.rd_sel   = RD_PM2;
          if (st.ptr_one) begin
            state_next = S_PLACE;
          end
        end else begin
          state_next = S_PLACE;
        end
      end
      S_UP_ISS: begin
        if (st.ptr_last) begin
          state_next = S_PLACE;
        end else begin
          cmd.rd_sel = RD_PP1;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (st.lt_x) begin
          cmd.wr_shift = 1'b1;
          cmd.ptr_op   = PTR_INC;
          cmd.rd_sel   = RD_PP2;
          if (st.ptr_penult) begin
            state_next = S_PLACE;
          end
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.wr_place = 1'b1;
        state_next   = S_BND;
      end
      S_BND: begin
        cmd.bnd_start = 1'b1;
        if (st.count_lt_n) begin
          state_next = S_OUT;
        end else if (st.mode_walk) begin
          state_next = S_WP1;
        end else begin
          cmd.set_fixed = 1'b1;
          state_next    = S_RLO;
        end
      end
      S_WP1: begin
        cmd.mul_op = MUL_TL;
        state_next = S_WP2;
      end
      S_WP2: begin
        cmd.tfp_load = 1'b1;
        cmd.mul_op   = MUL_TH;
        state_next   = S_WP3;
      end
      S_WP3: begin
        cmd.tfp_add = 1'b1;
        cmd.rd_sel  = RD_ZERO;
        state_next  = S_WL1;
      end
      S_WL1: begin
        cmd.wacc_load = 1'b1;
        cmd.ptr_op    = PTR_ZERO;
        cmd.rd_sel    = RD_ONE;
        state_next    = S_WLS;
      end
      S_WLS: begin
        if (!st.ptr_last && st.below) begin
          cmd.wacc_add = 1'b1;
          cmd.ptr_op   = PTR_INC;
          cmd.rd_sel   = RD_PP2;
        end else begin
          cmd.set_li = 1'b1;
          state_next = S_WH0;
        end
      end
      S_WH0: begin
        cmd.rd_sel = RD_LAST;
        state_next = S_WH1;
      end
      S_WH1: begin
        cmd.wacc_load = 1'b1;
        cmd.ptr_op    = PTR_LAST;
        cmd.rd_sel    = RD_LASTM1;
        state_next    = S_WHS;
      end
      S_WHS: begin
        if (!st.ptr_zero && st.below) begin
          cmd.wacc_add = 1'b1;
          cmd.ptr_op   = PTR_DEC;
          cmd.rd_sel   = RD_PM2;
        end else begin
          cmd.set_hix = 1'b1;
          state_next  = S_RLO;
        end
      end
      S_RLO: begin
        cmd.rd_sel = RD_LI;
        state_next = S_RHI;
      end
      S_RHI: begin
        cmd.lo_load = 1'b1;
        cmd.rd_sel  = RD_HIX;
        state_next  = S_RDN;
      end
      S_RDN: begin
        cmd.hi_load = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

`ifndef SYNTH
  a_done_then_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("tracker still busy after delivering a word");
  a_start_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted word did not start the sequencer");
  a_dn_hole: assert property (@(posedge clk) disable iff (rst)
      (state == S_DN_CMP) |-> !st.ptr_zero)
    else $error("downward shift ran past the bottom of the store");
`endif

endmodule

### rtl/dtt_dp.sv
// Datapath of the tracker: sorted stores, accumulators, shared multiplier, walk.
module dtt_dp import dtt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dtt_cmd_t           cmd,
  output dtt_status_t        st,
  input  logic               func,
  input  logic signed [31:0] sample,
  input  logic [31:0]        sample_weight,
  input  logic               weight_given,
  input  logic [1:0]         mode,
  input  logic [10:0]        store_count,
  input  logic [9:0]         low_index,
  input  logic [9:0]         high_index,
  input  logic [15:0]        tail_frac,
  output logic signed [31:0] low_bound,
  output logic signed [31:0] high_bound,
  output logic               bounds_valid,
  output logic [31:0]        sample_count,
  output logic signed [63:0] weighted_sum,
  output logic [62:0]        weighted_square_sum,
  output logic [62:0]        weight_total,
  output logic               rejected
);

  localparam logic [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SUM_MIN = 64'h8000_0000_0000_0000;
  localparam logic [62:0] MAX63   = {63{1'b1}};

  logic signed [31:0] x_q;
  logic [31:0]        wt_q, mag_q, mlo;
  logic               neg_q, fill_q;
  logic [63:0]        prod, sqp;
  logic [31:0]        mul_a, mul_b;
  logic [31:0]        count_q;
  logic [63:0]        sum_acc;
  logic [62:0]        sq_acc, w_acc;
  logic [TFP_W-1:0]   tfp;
  logic [ACC_W-1:0]   wacc;
  logic [ADDR_W-1:0]  ptr, li, hix, raddr, half, nm1;
  logic [SIZE_W-1:0]  n;
  logic [31:0]        sc32, n32;
  logic [ADDR_W+1:0]  ptr_x, n_x;
  logic [31:0]        rd_v, rd_w;
  logic signed [31:0] lo_q, hi_q;
  logic               valid_q, rej_q;
  logic               wen;

  logic [31:0] vmem [STORE_DEPTH];
  logic [31:0] wmem [STORE_DEPTH];

  logic [64:0] sum_wide, sq_wide;
  logic [63:0] sq_term, w_wide;

  // active size of the store
  always_comb begin
    sc32 = 32'(store_count);
    n32  = sc32;
    if (sc32 < 32'd2) begin
      n32 = 32'd2;
    end
    if (n32 > 32'(STORE_DEPTH)) begin
      n32 = 32'(STORE_DEPTH);
    end
    if (mode == MODE_TAIL) begin
      n32[0] = 1'b0;
    end
  end

  assign n     = SIZE_W'(n32);
  assign half  = ADDR_W'(n32 >> 1);
  assign nm1   = ADDR_W'(n32 - 32'd1);
  assign ptr_x = (ADDR_W+2)'(ptr);
  assign n_x   = (ADDR_W+2)'(n);

  assign st.func_clear = func;
  assign st.mode_full  = (mode != MODE_TAIL);
  assign st.mode_walk  = mode[1];
  assign st.count_lt_n = (count_q < 32'(n));
  assign st.ptr_zero   = (ptr == '0);
  assign st.ptr_one    = (ptr == ADDR_W'(1));
  assign st.ptr_last   = ((ptr_x + (ADDR_W+2)'(1)) >= n_x);
  assign st.ptr_penult = ((ptr_x + (ADDR_W+2)'(2)) >= n_x);
  assign st.gt_x       = ($signed(rd_v) > x_q);
  assign st.lt_x       = ($signed(rd_v) < x_q);
  assign st.below      = (TFP_W'({wacc, 16'h0000}) < tfp);

  always_comb begin
    case (cmd.rd_sel)
      RD_PTR:    raddr = ptr;
      RD_PM1:    raddr = ptr - ADDR_W'(1);
      RD_PM2:    raddr = ptr - ADDR_W'(2);
      RD_PP1:    raddr = ptr + ADDR_W'(1);
      RD_PP2:    raddr = ptr + ADDR_W'(2);
      RD_HALF:   raddr = half;
      RD_HALFM1: raddr = half - ADDR_W'(1);
      RD_ZERO:   raddr = '0;
      RD_ONE:    raddr = ADDR_W'(1);
      RD_LAST:   raddr = nm1;
      RD_LASTM1: raddr = nm1 - ADDR_W'(1);
      RD_LI:     raddr = li;
      RD_HIX:    raddr = hix;
      default:   raddr = ptr;
    endcase
  end

  assign wen = cmd.wr_shift || cmd.wr_place;

  always_ff @(posedge clk) begin
    if (wen) begin
      vmem[ptr] <= cmd.wr_place ? x_q : rd_v;
    end
    rd_v <= vmem[raddr];
  end

  // weights move only while the store is filling
  always_ff @(posedge clk) begin
    if (wen && fill_q) begin
      wmem[ptr] <= cmd.wr_place ? wt_q : rd_w;
    end
    rd_w <= wmem[raddr];
  end

  always_comb begin
    case (cmd.mul_op)
      MUL_SW: begin
        mul_a = mag_q;
        mul_b = wt_q;
      end
      MUL_SQ: begin
        mul_a = mag_q;
        mul_b = mag_q;
      end
      MUL_HI: begin
        mul_a = prod[63:32];
        mul_b = wt_q;
      end
      MUL_LO: begin
        mul_a = mlo;
        mul_b = wt_q;
      end
      MUL_TL: begin
        mul_a = w_acc[31:0];
        mul_b = 32'(tail_frac);
      end
      MUL_TH: begin
        mul_a = {1'b0, w_acc[62:32]};
        mul_b = 32'(tail_frac);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    sum_wide = cmd.acc_sum && neg_q ? {sum_acc[63], sum_acc} - 65'(prod[63:16])
                                    : {sum_acc[63], sum_acc} + 65'(prod[63:16]);
    sq_term  = sqp + 64'(prod[63:32]);
    sq_wide  = 65'(sq_acc) + 65'(sq_term);
    w_wide   = 64'(w_acc) + 64'(wt_q);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_q   <= sample;
      wt_q  <= weight_given ? sample_weight : Q_ONE;
      mag_q <= sample[31] ? (~sample + 32'd1) : sample;
      neg_q <= sample[31];
    end
    if (cmd.mul_op != MUL_NONE) begin
      prod <= {32'h0, mul_a} * {32'h0, mul_b};
    end
    if (cmd.save_mlo) begin
      mlo <= prod[31:0];
    end
    if (cmd.save_sqp) begin
      sqp <= prod;
    end
    if (cmd.tfp_load) begin
      tfp <= TFP_W'(prod);
    end else if (cmd.tfp_add) begin
      tfp <= tfp + {prod[TFP_W-33:0], 32'h0};
    end
    if (cmd.wacc_load) begin
      wacc <= ACC_W'(rd_w);
    end else if (cmd.wacc_add) begin
      wacc <= wacc + ACC_W'(rd_w);
    end
    case (cmd.ptr_op)
      PTR_COUNT:  ptr <= ADDR_W'(count_q);
      PTR_HALF:   ptr <= half;
      PTR_HALFM1: ptr <= half - ADDR_W'(1);
      PTR_INC:    ptr <= ptr + ADDR_W'(1);
      PTR_DEC:    ptr <= ptr - ADDR_W'(1);
      PTR_ZERO:   ptr <= '0;
      PTR_LAST:   ptr <= nm1;
      default:    ptr <= ptr;
    endcase
    if (cmd.ptr_op == PTR_COUNT) begin
      fill_q <= 1'b1;
    end else if (cmd.ptr_op == PTR_HALF || cmd.ptr_op == PTR_HALFM1) begin
      fill_q <= 1'b0;
    end
    if (cmd.set_fixed) begin
      if (mode == MODE_TAIL) begin
        li  <= half - ADDR_W'(1);
        hix <= half;
      end else begin
        li  <= (32'(low_index) < 32'(n)) ? ADDR_W'(low_index) : nm1;
        hix <= (32'(high_index) < 32'(n)) ? ADDR_W'(high_index) : nm1;
      end
    end
    if (cmd.set_li) begin
      li <= st.ptr_zero ? '0 : ptr - ADDR_W'(1);
    end
    if (cmd.set_hix) begin
      hix <= st.ptr_last ? nm1 : ptr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_q <= '0;
      sum_acc <= '0;
      sq_acc  <= '0;
      w_acc   <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      valid_q <= 1'b0;
      rej_q   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count_q <= '0;
        sum_acc <= '0;
        sq_acc  <= '0;
        w_acc   <= '0;
      end
      if (cmd.acc_sum) begin
        if (sum_wide[64] != sum_wide[63]) begin
          sum_acc <= sum_wide[64] ? SUM_MIN : SUM_MAX;
        end else begin
          sum_acc <= sum_wide[63:0];
        end
      end
      if (cmd.acc_sq) begin
        sq_acc <= (sq_wide > 65'(MAX63)) ? MAX63 : sq_wide[62:0];
        w_acc  <= (w_wide > 64'(MAX63)) ? MAX63 : w_wide[62:0];
      end
      if (cmd.count_inc && count_q != 32'hFFFF_FFFF) begin
        count_q <= count_q + 32'd1;
      end
      if (cmd.load) begin
        rej_q <= 1'b0;
      end else if (cmd.reject) begin
        rej_q <= 1'b1;
      end
      if (cmd.bnd_start) begin
        valid_q <= !st.count_lt_n;
        if (st.count_lt_n) begin
          lo_q <= '0;
          hi_q <= '0;
        end
      end
      if (cmd.lo_load) begin
        lo_q <= $signed(rd_v);
      end
      if (cmd.hi_load) begin
        hi_q <= $signed(rd_v);
      end
    end
  end

  assign low_bound           = lo_q;
  assign high_bound          = hi_q;
  assign bounds_valid        = valid_q;
  assign sample_count        = count_q;
  assign weighted_sum        = $signed(sum_acc);
  assign weighted_square_sum = sq_acc;
  assign weight_total        = w_acc;
  assign rejected            = rej_q;

endmodule

### rtl/distribution_tail_tracker.sv
// Streaming confidence-interval tracker: register port, sequencer and datapath.
//
// Usage: raise start with func, sample, sample_weight and weight_given; the word
// is taken on an edge where busy is low. Exactly one result word follows,
// shown for a single cycle while done is high; the receiver cannot stall it.
// Registers sit on the APB port at byte addresses 0x00..0x10; the user must write
// them only while busy is low, which the block itself does not enforce.
// A clear resets the sums and the count and goes on to the bound step. A sample
// passes the shared 32x32 multiplier, the accumulators and the decision, then an
// insertion, if any, that shifts entries in the sorted store, a step that settles
// validity, then, once the store is full, the fixed-index bound reads or, in the
// weighted mode, a walk from each end of the store, and a result step.
// The single-port-read store memory sets the pace; the tracker takes one word at
// a time and accepts no new word while busy is high.
// Reset clears the sums, the count and the registers; the store holds no
// reset value and needs no clearing pass.
module distribution_tail_tracker import dtt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic signed [31:0] sample,
  input  logic [31:0]        sample_weight,
  input  logic               weight_given,
  output logic               done,
  output logic signed [31:0] low_bound,
  output logic signed [31:0] high_bound,
  output logic               bounds_valid,
  output logic [31:0]        sample_count,
  output logic signed [63:0] weighted_sum,
  output logic [62:0]        weighted_square_sum,
  output logic [62:0]        weight_total,
  output logic               rejected,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [1:0]  mode;
  logic [10:0] store_count;
  logic [9:0]  low_index, high_index;
  logic [15:0] tail_frac;
  logic        wr;
  logic [2:0]  idx;
  dtt_cmd_t    cmd;
  dtt_status_t st;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_RST;
      store_count <= STORE_COUNT_RST;
      low_index   <= LOW_INDEX_RST;
      high_index  <= HIGH_INDEX_RST;
      tail_frac   <= TAIL_FRAC_RST;
    end else if (wr) begin
      case (idx)
        REG_MODE:        mode        <= pwdata[1:0];
        REG_STORE_COUNT: store_count <= pwdata[10:0];
        REG_LOW_INDEX:   low_index   <= pwdata[9:0];
        REG_HIGH_INDEX:  high_index  <= pwdata[9:0];
        REG_TAIL_FRAC:   tail_frac   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:        prdata = 32'(mode);
      REG_STORE_COUNT: prdata = 32'(store_count);
      REG_LOW_INDEX:   prdata = 32'(low_index);
      REG_HIGH_INDEX:  prdata = 32'(high_index);
      REG_TAIL_FRAC:   prdata = 32'(tail_frac);
      default:         prdata = '0;
    endcase
  end

  dtt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  dtt_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .st                  (st),
    .func                (func),
    .sample              (sample),
    .sample_weight       (sample_weight),
    .weight_given        (weight_given),
    .mode                (mode),
    .store_count         (store_count),
    .low_index           (low_index),
    .high_index          (high_index),
    .tail_frac           (tail_frac),
    .low_bound           (low_bound),
    .high_bound          (high_bound),
    .bounds_valid        (bounds_valid),
    .sample_count        (sample_count),
    .weighted_sum        (weighted_sum),
    .weighted_square_sum (weighted_square_sum),
    .weight_total        (weight_total),
    .rejected            (rejected)
  );

endmodule
